// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files. Every use samples on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled clock edge.
`define SWPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true at a sampled clock edge.
`define SWPSC_ASSERT_NEVER(lbl, cond, msg) \
  `SWPSC_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/swpsc_pkg.sv =====
package swpsc_pkg;

  localparam int unsigned WINDOW_DEF = 25;
  localparam int unsigned VALUE_W    = 48;
  localparam int unsigned VERDICT_W  = 2;
  // Cycles between the last window read and a settled hit flag.
  localparam int unsigned DRAIN_CYC  = 2;

  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_LOADED  = 2'd0,
    VERDICT_PAIR    = 2'd1,
    VERDICT_NO_PAIR = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // latch the incoming value
    logic rd_en;    // read one window entry for the scan
    logic clr_hit;  // clear the pair-found flag
    logic wr_en;    // write the latched value into the window
    logic emit;     // hand the result to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;      // some scanned entry has a partner in the window
  } status_t;

endpackage

// ===== src/swpsc_ram.sv =====
module swpsc_ram #(
  parameter int unsigned WIDTH  = 48,
  parameter int unsigned DEPTH  = 25,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/swpsc_dp.sv =====
`include "assert_macros.svh"

module swpsc_dp #(
  parameter int unsigned WINDOW = swpsc_pkg::WINDOW_DEF,
  parameter int unsigned IDX_W  = $clog2(WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swpsc_pkg::cmd_t        cmd_i,
  input  swpsc_pkg::value_t      value_i,
  input  logic [IDX_W-1:0]       rd_addr_i,
  input  logic [IDX_W-1:0]       wr_addr_i,
  output swpsc_pkg::status_t     status_o,
  output swpsc_pkg::value_t      value_o
);

  import swpsc_pkg::*;

  value_t             value_q;
  value_t             rd_data;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [VALUE_W:0]   diff;
  value_t             diff_q;
  logic               diff_vld_q;
  logic [IDX_W-1:0]   diff_idx_q;
  value_t             lane_q [WINDOW];
  logic [WINDOW-1:0]  match;
  logic               hit_d;
  logic               hit_q;

  // Scan copy of the window, read one entry per cycle.
  swpsc_ram #(
    .WIDTH  (VALUE_W),
    .DEPTH  (WINDOW),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (value_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      value_q <= value_i;
    end
    rd_idx_q   <= rd_addr_i;
    diff_q     <= diff[VALUE_W-1:0];
    diff_idx_q <= rd_idx_q;
  end

  // The partner each entry needs; a borrow means no partner can exist.
  assign diff = {1'b0, value_q} - {1'b0, rd_data};

  // Compare lanes: every other window entry checked against the partner value.
  for (genvar k = 0; k < WINDOW; k++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (cmd_i.wr_en && (wr_addr_i == IDX_W'(k))) begin
        lane_q[k] <= value_q;
      end
    end
    assign match[k] = (lane_q[k] == diff_q) && (diff_idx_q != IDX_W'(k));
  end

  always_comb begin
    hit_d = hit_q;
    if (cmd_i.clr_hit) begin
      hit_d = 1'b0;
    end else if (diff_vld_q && (|match)) begin
      hit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      diff_vld_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.rd_en;
      diff_vld_q <= rd_vld_q && !diff[VALUE_W];
      hit_q      <= hit_d;
    end
  end

  assign status_o.hit = hit_q;
  assign value_o      = value_q;

  `SWPSC_ASSERT(a_hit_from_scan, $rose(hit_q) |-> $past(diff_vld_q), "hit set without a scan")

endmodule

// ===== src/swpsc_ctrl.sv =====
`include "assert_macros.svh"

module swpsc_ctrl #(
  parameter int unsigned WINDOW = swpsc_pkg::WINDOW_DEF,
  parameter int unsigned IDX_W  = $clog2(WINDOW)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic                  restart_i,
  input  logic                  out_free_i,
  input  swpsc_pkg::status_t    status_i,
  output logic                  ready_o,
  output swpsc_pkg::cmd_t       cmd_o,
  output logic [IDX_W-1:0]      rd_addr_o,
  output logic [IDX_W-1:0]      wr_addr_o,
  output swpsc_pkg::verdict_e   verdict_o
);

  import swpsc_pkg::*;

  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
  localparam int unsigned DRAIN_W = (DRAIN_CYC > 1) ? $clog2(DRAIN_CYC) : 1;

  state_e             state_d, state_q;
  logic [CNT_W-1:0]   fill_d, fill_q;
  logic [CNT_W-1:0]   fill_n;
  logic [IDX_W-1:0]   oldest_d, oldest_q;
  logic [IDX_W-1:0]   cnt_d, cnt_q;
  logic [DRAIN_W-1:0] drain_d, drain_q;
  logic               load_d, load_q;
  logic [IDX_W-1:0]   wr_idx_d, wr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      oldest_q <= '0;
      cnt_q    <= '0;
      drain_q  <= '0;
      load_q   <= 1'b0;
      wr_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      cnt_q    <= cnt_d;
      drain_q  <= drain_d;
      load_q   <= load_d;
      wr_idx_q <= wr_idx_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    oldest_d  = oldest_q;
    cnt_d     = cnt_q;
    drain_d   = drain_q;
    load_d    = load_q;
    wr_idx_d  = wr_idx_q;
    fill_n    = restart_i ? '0 : fill_q;
    cmd_o     = '0;
    ready_o   = 1'b0;
    verdict_o = VERDICT_LOADED;

    unique case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (take_i) begin
          cmd_o.take = 1'b1;
          if (restart_i) begin
            oldest_d = '0;
          end
          if (fill_n < CNT_W'(WINDOW)) begin
            // Still filling the window: store without a check.
            load_d   = 1'b1;
            wr_idx_d = fill_n[IDX_W-1:0];
            fill_d   = fill_n + CNT_W'(1);
            state_d  = ST_RESULT;
          end else begin
            load_d        = 1'b0;
            cnt_d         = '0;
            cmd_o.clr_hit = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_q == IDX_W'(WINDOW - 1)) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_q == DRAIN_W'(DRAIN_CYC - 1)) begin
          state_d = ST_RESULT;
        end else begin
          drain_d = drain_q + DRAIN_W'(1);
        end
      end
      ST_RESULT: begin
        if (load_q) begin
          verdict_o = VERDICT_LOADED;
        end else if (status_i.hit) begin
          verdict_o = VERDICT_PAIR;
        end else begin
          verdict_o = VERDICT_NO_PAIR;
        end
        if (out_free_i) begin
          cmd_o.emit  = 1'b1;
          cmd_o.wr_en = load_q || status_i.hit;
          if (!load_q && status_i.hit) begin
            oldest_d = (oldest_q == IDX_W'(WINDOW - 1)) ? '0 : oldest_q + IDX_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o = cnt_q;
  assign wr_addr_o = load_q ? wr_idx_q : oldest_q;

  `SWPSC_ASSERT_NEVER(a_fill_range, fill_q > CNT_W'(WINDOW), "fill count beyond window")
  `SWPSC_ASSERT_NEVER(a_oldest_range, oldest_q > IDX_W'(WINDOW - 1), "oldest slot out of range")
  `SWPSC_ASSERT(a_scan_full, (state_q == ST_SCAN) |-> (fill_q == CNT_W'(WINDOW)), "scan before full")

endmodule

// ===== src/sliding_window_pair_sum_check.sv =====
// Flow: a window-filling beat goes from IDLE straight to RESULT; a checked beat
// passes through SCAN and DRAIN first. Each result then waits in RESULT until
// the output register is free, and no new beat is accepted until then. Once the
// window is full, the pace is set by the scan, which reads one entry per cycle.
// Reset: rst_ni is asynchronous and active low; it empties the window (the next
// WINDOW beats refill it) and drops any pending result. Window data is not cleared.
`include "assert_macros.svh"

module sliding_window_pair_sum_check #(
  parameter int unsigned WINDOW = swpsc_pkg::WINDOW_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swpsc_pkg::VALUE_W-1:0]   s_axis_tdata,  // [47:0] sample_value
  input  logic                            s_axis_tuser,  // [0] restart
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [swpsc_pkg::VALUE_W-1:0]   m_axis_tdata,  // [47:0] echoed_value
  output logic [swpsc_pkg::VERDICT_W-1:0] m_axis_tuser   // [1:0] verdict
);

  import swpsc_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW);

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  verdict_e         verdict;
  value_t           value;
  logic             take;
  logic             out_free;

  // Output register: holds one finished result so the next beat can be
  // accepted while the downstream side stalls.
  logic             out_vld_q;
  value_t           out_data_q;
  verdict_e         out_verdict_q;

  assign take     = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  // The controller sequences filling, the scan, the drain of the compare
  // pipeline and the window update.
  swpsc_ctrl #(
    .WINDOW (WINDOW),
    .IDX_W  (IDX_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .restart_i  (s_axis_tuser),
    .out_free_i (out_free),
    .status_i   (status),
    .ready_o    (s_axis_tready),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .verdict_o  (verdict)
  );

  // The datapath holds the window twice: a RAM for the per-cycle scan read
  // and a row of registers that all compare in parallel against the partner
  // value of the entry just read.
  swpsc_dp #(
    .WINDOW (WINDOW),
    .IDX_W  (IDX_W)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_i   (s_axis_tdata),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .status_o  (status),
    .value_o   (value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_data_q    <= value;
      out_verdict_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_verdict_q;

  `SWPSC_ASSERT(a_emit_free, cmd.emit |-> (!out_vld_q || m_axis_tready), "result overwritten")
  `SWPSC_ASSERT_NEVER(a_take_busy, take && !$past(cmd.emit) && cmd.emit, "emit on accept")

endmodule
